/* sv/vbqe_pkg.sv */
// Package: shared constants and lookup functions for the voxel quad emitter.
`default_nettype none
package vbqe_pkg;
  localparam int unsigned ChunkEdge = 32;
  localparam logic [4:0] TypeWater = 5'd6;
  localparam logic [4:0] TypeMax = 5'd18;
  localparam logic [4:0] TypePlantA = 5'd10;
  localparam logic [4:0] TypePlantB = 5'd14;
  localparam logic [31:0] MulA = 32'h7feb352d;
  localparam logic [31:0] MulB = 32'h846ca68b;
  localparam logic [31:0] OffY = 32'h000000e1;
  localparam logic [31:0] OffZ = 32'h0000ac83;

  // Bit t is set when type t rotates its UVs.
  function automatic logic rotatable(input logic [4:0] t);
    logic [18:0] m;
    m = 19'b1111_0011_0011_1110_110;
    rotatable = (t <= TypeMax) ? m[t] : 1'b0;
  endfunction

  function automatic logic [7:0] face_light(input logic [2:0] f);
    unique case (f)
      3'd0: face_light = 8'd255;
      3'd1: face_light = 8'd229;
      3'd2, 3'd3: face_light = 8'd240;
      default: face_light = 8'd220;
    endcase
  endfunction

  // Corner offsets {dx,dy,dz} for face f, vertex v.
  function automatic logic [2:0] cube_off(input logic [2:0] f, input logic [1:0] v);
    logic [11:0] row;
    unique case (f)
      3'd0: row = {3'b010, 3'b110, 3'b111, 3'b011};
      3'd1: row = {3'b000, 3'b100, 3'b101, 3'b001};
      3'd2: row = {3'b111, 3'b110, 3'b100, 3'b101};
      3'd3: row = {3'b011, 3'b010, 3'b000, 3'b001};
      3'd4: row = {3'b011, 3'b111, 3'b101, 3'b001};
      default: row = {3'b010, 3'b110, 3'b100, 3'b000};
    endcase
    cube_off = row[11 - 3 * v -: 3];
  endfunction
endpackage
`default_nettype wire

/* sv/vbqe_hash.sv */
// Iterative position hash: one shared 32x32 multiplier, one step per cycle.
`default_nettype none
module vbqe_hash (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [31:0] wx,
  input  wire logic [31:0] wy,
  input  wire logic [31:0] wz,
  output logic             done,
  output logic [1:0]       rot
);
  typedef enum logic [2:0] {S_IDLE, S_PRE, S_M1, S_X1, S_M2, S_FIN} st_t;
  st_t st_r;
  logic [1:0]  word_r;
  logic [31:0] x_r, acc_r, wx_r, wy_r, wz_r;
  logic [31:0] mul_b, prod;
  logic [31:0] fin;

  assign mul_b = (st_r == S_M1) ? vbqe_pkg::MulA : vbqe_pkg::MulB;
  assign prod = 32'(x_r * mul_b);
  assign fin = x_r ^ (x_r >> 16);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (st_r)
        S_IDLE: if (start) begin
          // word 0 is the constant 1, then wx, wy, wz
          x_r <= 32'd1;
          acc_r <= 32'd0;
          word_r <= 2'd0;
          wx_r <= wx;
          wy_r <= wy;
          wz_r <= wz;
          rot <= 2'd0;
          st_r <= S_PRE;
        end
        S_PRE: begin
          x_r <= x_r ^ (x_r >> 16);
          st_r <= S_M1;
        end
        S_M1: begin
          x_r <= prod;
          st_r <= S_X1;
        end
        S_X1: begin
          x_r <= x_r ^ (x_r >> 15);
          st_r <= S_M2;
        end
        S_M2: begin
          x_r <= prod;
          st_r <= S_FIN;
        end
        default: begin
          acc_r <= acc_r ^ fin;
          word_r <= 2'(word_r + 2'd1);
          unique case (word_r)
            2'd0: x_r <= wx_r;
            2'd1: x_r <= 32'(wy_r + vbqe_pkg::OffY);
            2'd2: x_r <= 32'(wz_r + vbqe_pkg::OffZ);
            default: x_r <= 32'd0;
          endcase
          if (word_r == 2'd3) begin
            rot <= acc_r[1:0] ^ fin[1:0];
            done <= 1'b1;
            st_r <= S_IDLE;
          end else begin
            st_r <= S_PRE;
          end
        end
      endcase
    end
  end
endmodule
`default_nettype wire

/* sv/voxel_block_quad_emitter_core.sv */
// Top level: voxel to quad-vertex emitter.
//
// Input channel in_*: one voxel per item, accepted when in_valid && !in_stall.
// Output channel out_*: one vertex per item, accepted when out_valid && !out_stall;
// out_last marks the final vertex of a voxel. Voxels that emit nothing give no item.
//
// Flow: a voxel whose type rotates its UVs first runs the position hash, four
// words through one shared 32x32 multiplier; the hash raises done, and the
// sequencer then takes the rotation and moves on to emission. Its vertices are
// registered one per cycle while the output is not stalled (up to 24), and the
// next voxel is taken only after the last of them. Other types skip the hash
// and go straight to emission; a voxel that emits nothing never leaves idle,
// so in_stall stays low for it.
// in_stall is high from acceptance until the last vertex of the voxel has
// been loaded into the output register.
//
// A receiver stall holds the output register; the vertex sequencer waits.
// Reset (rst_n low, synchronous) clears both vertex counters, the sequencer
// and out_valid.
`default_nettype none
module voxel_block_quad_emitter_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_new_chunk,
  input  wire logic [4:0]  in_block_type,
  input  wire logic [4:0]  in_local_x,
  input  wire logic [4:0]  in_local_y,
  input  wire logic [4:0]  in_local_z,
  input  wire logic [31:0] in_world_x,
  input  wire logic [31:0] in_world_y,
  input  wire logic [31:0] in_world_z,
  input  wire logic [5:0]  in_neighbour_solid,
  input  wire logic [4:0]  in_above_type,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [9:0]       out_pos_x,
  output logic [9:0]       out_pos_y,
  output logic [9:0]       out_pos_z,
  output logic [4:0]       out_texture_id,
  output logic [7:0]       out_tex_u,
  output logic [7:0]       out_tex_v,
  output logic [7:0]       out_light,
  output logic             out_layer,
  output logic [1:0]       out_winding,
  output logic [19:0]      out_quad_base,
  output logic             out_last
);
  typedef enum logic [1:0] {ST_IDLE, ST_HASH, ST_EMIT} st_t;
  typedef enum logic [1:0] {K_CUBE, K_PLANT, K_WATER} kind_t;

  st_t   st_r;
  kind_t kind_r;
  logic [4:0] type_r, x_r, y_r, z_r;
  logic [5:0] solid_r;
  logic [1:0] rot_r;
  logic [2:0] face_r;
  logic [1:0] vtx_r;
  logic [19:0] ocnt_r, tcnt_r;

  logic hash_start, hash_done;
  logic [1:0] hash_rot;

  vbqe_hash u_hash (
    .clk(clk), .rst_n(rst_n), .start(hash_start),
    .wx(in_world_x), .wy(in_world_y), .wz(in_world_z),
    .done(hash_done), .rot(hash_rot)
  );

  logic acc_in, out_free, emit_go;
  logic [4:0] ty;
  logic in_range, emits, water_skip;
  logic [2:0] first_face;
  assign acc_in = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign emit_go = (st_r == ST_EMIT) && out_free;
  assign ty = in_block_type;
  assign in_range = (32'(in_local_x) < vbqe_pkg::ChunkEdge)
                 && (32'(in_local_y) < vbqe_pkg::ChunkEdge)
                 && (32'(in_local_z) < vbqe_pkg::ChunkEdge);
  assign water_skip = (ty == vbqe_pkg::TypeWater) && (in_above_type == ty);
  assign emits = (ty != 5'd0) && (ty <= vbqe_pkg::TypeMax) && in_range && !water_skip
              && !((ty != vbqe_pkg::TypeWater) && (ty != vbqe_pkg::TypePlantA)
                   && (ty != vbqe_pkg::TypePlantB) && (in_neighbour_solid == 6'h3f));
  assign hash_start = acc_in && emits && vbqe_pkg::rotatable(ty);
  assign in_stall = (st_r != ST_IDLE);

  // Lowest open face of the incoming voxel.
  always_comb begin
    first_face = 3'd0;
    for (int i = 5; i >= 0; i--) begin
      if (!in_neighbour_solid[i]) first_face = 3'(i);
    end
  end

  // Current vertex fields.
  logic [2:0] off;
  logic [1:0] r;
  logic [7:0] u_c, v_c;
  logic [5:0] ux, uy, uz;
  logic       last_face, last_c;
  logic [2:0] nxt_face;
  logic [5:0] rem_mask;
  assign r = 2'(vtx_r + rot_r);
  assign u_c = (r == 2'd1 || r == 2'd2) ? 8'd255 : 8'd0;
  assign v_c = r[1] ? 8'd255 : 8'd0;

  always_comb begin
    off = 3'b000;
    unique case (kind_r)
      K_PLANT: begin
        unique case (vtx_r)
          2'd0: off = {1'b0, 1'b1, ~face_r[0]};
          2'd1: off = {1'b1, 1'b1, face_r[0]};
          2'd2: off = {1'b1, 1'b0, face_r[0]};
          default: off = {1'b0, 1'b0, ~face_r[0]};
        endcase
      end
      K_WATER: begin
        unique case (vtx_r)
          2'd0: off = 3'b000;
          2'd1: off = 3'b100;
          2'd2: off = 3'b101;
          default: off = 3'b001;
        endcase
      end
      default: off = vbqe_pkg::cube_off(face_r, vtx_r);
    endcase
  end

  assign ux = 6'(x_r) + 6'(off[2]);
  assign uy = 6'(y_r) + 6'(off[1]);
  assign uz = 6'(z_r) + 6'(off[0]);

  always_comb begin
    rem_mask = 6'h00;
    for (int i = 0; i < 6; i++) begin
      if (3'(i) > face_r) rem_mask[i] = ~solid_r[i];
    end
    nxt_face = face_r;
    for (int i = 5; i >= 0; i--) begin
      if (rem_mask[i]) nxt_face = 3'(i);
    end
  end
  assign last_face = (kind_r == K_CUBE) ? (rem_mask == 6'h00) : face_r[0];
  assign last_c = last_face && (vtx_r == 2'd3);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      out_valid <= 1'b0;
      ocnt_r <= '0;
      tcnt_r <= '0;
    end else begin
      if (emit_go) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      unique case (st_r)
        ST_IDLE: if (acc_in) begin
          if (in_new_chunk) begin
            ocnt_r <= '0;
            tcnt_r <= '0;
          end
          type_r <= ty;
          x_r <= in_local_x;
          y_r <= in_local_y;
          z_r <= in_local_z;
          solid_r <= in_neighbour_solid;
          rot_r <= 2'd0;
          vtx_r <= 2'd0;
          if (ty == vbqe_pkg::TypePlantA || ty == vbqe_pkg::TypePlantB) begin
            kind_r <= K_PLANT;
            face_r <= 3'd0;
          end else if (ty == vbqe_pkg::TypeWater) begin
            kind_r <= K_WATER;
            face_r <= 3'd0;
          end else begin
            kind_r <= K_CUBE;
            face_r <= first_face;
          end
          if (emits) st_r <= vbqe_pkg::rotatable(ty) ? ST_HASH : ST_EMIT;
        end
        ST_HASH: if (hash_done) begin
          rot_r <= hash_rot;
          st_r <= ST_EMIT;
        end
        default: if (out_free) begin
          out_pos_x <= {ux, 4'd0};
          out_pos_y <= (kind_r == K_WATER) ? 10'({y_r, 4'd0} + 9'd13) : {uy, 4'd0};
          out_pos_z <= {uz, 4'd0};
          out_texture_id <= (type_r == 5'd1) ? 5'd0 : type_r;
          out_tex_u <= u_c;
          out_tex_v <= v_c;
          out_layer <= (kind_r == K_WATER);
          unique case (kind_r)
            K_PLANT: begin
              out_light <= 8'd255;
              out_winding <= 2'd2;
            end
            K_WATER: begin
              out_light <= vbqe_pkg::face_light(face_r);
              out_winding <= {1'b0, face_r[0]};
            end
            default: begin
              out_light <= vbqe_pkg::face_light(face_r);
              out_winding <= {1'b0, face_r[0]};
            end
          endcase
          out_quad_base <= (kind_r == K_WATER) ? tcnt_r : ocnt_r;
          out_last <= last_c;
          vtx_r <= 2'(vtx_r + 2'd1);
          if (vtx_r == 2'd3) begin
            if (kind_r == K_WATER) tcnt_r <= 20'(tcnt_r + 20'd4);
            else ocnt_r <= 20'(ocnt_r + 20'd4);
            face_r <= (kind_r == K_CUBE) ? nxt_face : 3'd1;
            if (last_face) st_r <= ST_IDLE;
          end
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_hash_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
    hash_done |-> st_r == ST_HASH) else $error("hash done outside hash phase");
  a_idle_no_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_IDLE) |=> !($rose(out_valid) && $past(st_r) == ST_IDLE))
    else $error("vertex without voxel");
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_EMIT && out_free && last_c) |=> st_r == ST_IDLE)
    else $error("sequencer did not finish after last vertex");
`endif
endmodule
`default_nettype wire
